FILE: rtl/iort_pkg.sv
// Shared package for the in-order receive tracker.
// Field widths, result kinds, datapath command codes and the control/status structs.
// No dependencies.
`default_nettype none

package iort_pkg;

  localparam int unsigned NUM_W      = 20;
  localparam int unsigned HANDLE_W   = 16;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned NACK_W     = 4;
  localparam int unsigned DATA_W     = 40;   // number + handle, padded to bytes
  localparam int unsigned WINDOW_DEF = 64;

  localparam int unsigned MAX_RESULTS = 64;  // most deliveries per arrival
  localparam int unsigned CNT_W       = 7;   // holds 0..MAX_RESULTS
  localparam int unsigned NACK_MAX    = 8;

  localparam logic [NACK_W-1:0] NACK_RESET = 4'd5;

  // configuration register indexes
  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_NACK  = 1'b1;

  // request types
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DELIVER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MISSING = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 3'd4;

  // datapath commands
  localparam int unsigned OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE   = 4'd1;
  localparam logic [OP_W-1:0] OP_HOLD      = 4'd2;
  localparam logic [OP_W-1:0] OP_READ      = 4'd3;
  localparam logic [OP_W-1:0] OP_DELIVER   = 4'd4;
  localparam logic [OP_W-1:0] OP_REJECT    = 4'd5;
  localparam logic [OP_W-1:0] OP_DONE      = 4'd6;
  localparam logic [OP_W-1:0] OP_SCAN_INIT = 4'd7;
  localparam logic [OP_W-1:0] OP_SCAN_STEP = 4'd8;
  localparam logic [OP_W-1:0] OP_SCAN_END  = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic is_tick;      // captured request is a tick
    logic arr_old;      // arrival below next expected
    logic arr_reject;   // arrival beyond window or transfer
    logic done;         // completion already reported
    logic ne_ge_total;  // nothing left to receive
    logic drain_ok;     // next expected packet is held and may go out
    logic last_del;     // the delivery in hand ends the run
    logic scan_more;    // missing-number scan has further numbers to visit
    logic out_space;    // output register free this cycle
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/iort_dp.sv
// Datapath of the in-order receive tracker: config registers, window state,
// handle memory, scan pointer and the output register. Driven by iort_ctrl.
// Depends on iort_pkg.
`default_nettype none

module iort_dp #(
  parameter int unsigned WINDOW = iort_pkg::WINDOW_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_req_type,
  input  wire logic [iort_pkg::NUM_W-1:0]      in_packet_number,
  input  wire logic [iort_pkg::HANDLE_W-1:0]   in_payload_handle,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [iort_pkg::NUM_W-1:0]      cfg_wdata,
  input  wire iort_pkg::cmd_t                  cmd,
  output iort_pkg::sts_t                       sts,
  input  wire logic                            out_tready,
  output logic                                 out_valid,
  output logic [iort_pkg::KIND_W-1:0]          out_kind,
  output logic [iort_pkg::NUM_W-1:0]           out_number,
  output logic [iort_pkg::HANDLE_W-1:0]        out_handle,
  output logic                                 out_last
);

  localparam int unsigned SW = $clog2(WINDOW);
  localparam int unsigned NW = iort_pkg::NUM_W;
  localparam int unsigned HW = iort_pkg::HANDLE_W;
  localparam int unsigned CW = iort_pkg::CNT_W;
  localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW - 1);
  localparam logic [SW:0]   SLOT_WRAP = (SW + 1)'(WINDOW);
  localparam logic [NW:0]   WIN_EXT   = (NW + 1)'(WINDOW);
  localparam logic [CW-1:0] MAX_CNT   = CW'(iort_pkg::MAX_RESULTS);
  localparam logic [iort_pkg::NACK_W-1:0] NACK_TOP = iort_pkg::NACK_W'(iort_pkg::NACK_MAX);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  // configuration
  logic [NW-1:0]                 total_r;
  logic [iort_pkg::NACK_W-1:0]   nack_r;

  // window state
  logic [NW-1:0]     ne_r;
  logic [SW-1:0]     ne_slot_r;
  logic [WINDOW-1:0] hv_r;
  logic [HW-1:0]     handle_mem [WINDOW];
  logic [HW-1:0]     rd_r;
  logic              done_r;

  // captured request
  logic          req_r;
  logic [NW-1:0] pn_r;
  logic [HW-1:0] h_r;

  // drain / scan bookkeeping
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] s_r;
  logic [SW-1:0] s_slot_r;
  logic [NW-1:0] pend_r;
  logic          pend_v_r;

  // output register
  logic                        out_valid_r;
  logic [iort_pkg::KIND_W-1:0] out_kind_r;
  logic [NW-1:0]               out_num_r;
  logic [HW-1:0]               out_hnd_r;
  logic                        out_last_r;

  logic [NW:0]                 ne_win;
  logic [NW-1:0]               diff;
  logic [SW:0]                 slot_sum;
  logic [SW-1:0]               hold_slot;
  logic [SW-1:0]               ne_slot_nx;
  logic [NW-1:0]               ne_p1;
  logic [CW-1:0]               cnt_p1;
  logic [iort_pkg::NACK_W-1:0] lim;
  logic                        s_held;
  logic                        found;
  logic                        out_space;

  logic                        load;
  logic [iort_pkg::KIND_W-1:0] load_kind;
  logic [NW-1:0]               load_num;
  logic [HW-1:0]               load_hnd;
  logic                        load_last;

  assign ne_win     = {1'b0, ne_r} + WIN_EXT;
  // arrival lies in [ne, ne+WINDOW) when held, so its slot is ne_slot plus the offset
  assign diff       = pn_r - ne_r;
  assign slot_sum   = {1'b0, ne_slot_r} + {1'b0, diff[SW-1:0]};
  assign hold_slot  = (slot_sum >= SLOT_WRAP) ? SW'(slot_sum - SLOT_WRAP) : slot_sum[SW-1:0];
  assign ne_slot_nx = slot_inc(ne_slot_r);
  assign ne_p1      = ne_r + 1'b1;
  assign cnt_p1     = cnt_r + 1'b1;
  assign lim        = (nack_r == '0) ? iort_pkg::NACK_W'(1) :
                      (nack_r > NACK_TOP) ? NACK_TOP : nack_r;
  assign s_held     = ({1'b0, s_r} < ne_win) && hv_r[s_slot_r];
  assign out_space  = !out_valid_r || out_tready;
  // a new missing number pushes the pending one out, which needs room
  assign found      = sts.scan_more && !s_held && (!pend_v_r || out_space);

  always_comb begin
    sts.is_tick     = (req_r == iort_pkg::REQ_TICK);
    sts.arr_old     = pn_r < ne_r;
    sts.arr_reject  = (pn_r >= total_r) || ({1'b0, pn_r} >= ne_win);
    sts.done        = done_r;
    sts.ne_ge_total = ne_r >= total_r;
    sts.drain_ok    = (cnt_r < MAX_CNT) && (ne_r < total_r) && hv_r[ne_slot_r];
    sts.last_del    = !((cnt_p1 < MAX_CNT) && (ne_p1 < total_r) && hv_r[ne_slot_nx]);
    sts.scan_more   = (cnt_r < CW'(lim)) && (s_r < total_r);
    sts.out_space   = out_space;
  end

  always_comb begin
    load      = 1'b0;
    load_kind = iort_pkg::KIND_DELIVER;
    load_num  = ne_r;
    load_hnd  = rd_r;
    load_last = 1'b1;
    case (cmd.op)
      iort_pkg::OP_REJECT: begin
        load      = 1'b1;
        load_kind = iort_pkg::KIND_REJECT;
        load_num  = pn_r;
        load_hnd  = h_r;
      end
      iort_pkg::OP_DONE: begin
        load      = 1'b1;
        load_kind = iort_pkg::KIND_DONE;
        load_num  = '0;
        load_hnd  = '0;
      end
      iort_pkg::OP_DELIVER: begin
        load      = 1'b1;
        load_last = sts.last_del;
      end
      iort_pkg::OP_SCAN_STEP: begin
        load      = found && pend_v_r;
        load_kind = iort_pkg::KIND_MISSING;
        load_num  = pend_r;
        load_hnd  = '0;
        load_last = 1'b0;
      end
      iort_pkg::OP_SCAN_END: begin
        load      = 1'b1;
        load_kind = pend_v_r ? iort_pkg::KIND_MISSING : iort_pkg::KIND_EMPTY;
        load_num  = pend_v_r ? pend_r : '0;
        load_hnd  = '0;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      nack_r      <= iort_pkg::NACK_RESET;
      ne_r        <= '0;
      ne_slot_r   <= '0;
      hv_r        <= '0;
      done_r      <= 1'b0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          iort_pkg::CFG_TOTAL: total_r <= cfg_wdata;
          iort_pkg::CFG_NACK:  nack_r  <= cfg_wdata[iort_pkg::NACK_W-1:0];
        endcase
      end

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (cmd.op)
        iort_pkg::OP_HOLD: begin
          cnt_r <= '0;
          hv_r[hold_slot] <= 1'b1;
        end
        iort_pkg::OP_DELIVER: begin
          hv_r[ne_slot_r] <= 1'b0;
          ne_r            <= ne_p1;
          ne_slot_r       <= ne_slot_nx;
          cnt_r           <= cnt_p1;
        end
        iort_pkg::OP_DONE: begin
          done_r <= 1'b1;
        end
        iort_pkg::OP_SCAN_INIT: begin
          cnt_r    <= '0;
          pend_v_r <= 1'b0;
        end
        iort_pkg::OP_SCAN_STEP: begin
          if (found) begin
            pend_v_r <= 1'b1;
            cnt_r    <= cnt_p1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == iort_pkg::OP_CAPTURE) begin
      req_r <= in_req_type;
      pn_r  <= in_packet_number;
      h_r   <= in_payload_handle;
    end
    if (cmd.op == iort_pkg::OP_SCAN_INIT) begin
      s_r      <= ne_r;
      s_slot_r <= ne_slot_r;
    end
    // the pointer only waits when a found number cannot yet go out
    if (cmd.op == iort_pkg::OP_SCAN_STEP && sts.scan_more && (s_held || found)) begin
      s_r      <= s_r + 1'b1;
      s_slot_r <= slot_inc(s_slot_r);
      if (!s_held) begin
        pend_r <= s_r;
      end
    end
    if (load) begin
      out_kind_r <= load_kind;
      out_num_r  <= load_num;
      out_hnd_r  <= load_hnd;
      out_last_r <= load_last;
    end
  end

  // handle memory: first handle of a slot is kept on duplicates
  always_ff @(posedge clk) begin
    if (cmd.op == iort_pkg::OP_HOLD && !hv_r[hold_slot]) begin
      handle_mem[hold_slot] <= h_r;
    end
    if (cmd.op == iort_pkg::OP_READ) begin
      rd_r <= handle_mem[ne_slot_r];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_number = out_num_r;
  assign out_handle = out_hnd_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/iort_ctrl.sv
// Controller of the in-order receive tracker: sequences capture, classify,
// drain and missing-number scan. Depends on iort_pkg; drives iort_dp.
`default_nettype none

module iort_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire iort_pkg::sts_t sts,
  output iort_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DECIDE   = 3'd1;
  localparam logic [2:0] ST_DRAIN    = 3'd2;
  localparam logic [2:0] ST_DRAIN_RD = 3'd3;
  localparam logic [2:0] ST_SCAN     = 3'd4;
  localparam logic [2:0] ST_SCAN_END = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = iort_pkg::OP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = iort_pkg::OP_CAPTURE;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.is_tick) begin
          if (sts.done) begin
            state_nxt = ST_IDLE;
          end else if (sts.ne_ge_total) begin
            if (sts.out_space) begin
              cmd.op    = iort_pkg::OP_DONE;
              state_nxt = ST_IDLE;
            end
          end else begin
            cmd.op    = iort_pkg::OP_SCAN_INIT;
            state_nxt = ST_SCAN;
          end
        end else if (sts.arr_old) begin
          state_nxt = ST_IDLE;
        end else if (sts.arr_reject) begin
          if (sts.out_space) begin
            cmd.op    = iort_pkg::OP_REJECT;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.op    = iort_pkg::OP_HOLD;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.drain_ok) begin
          cmd.op    = iort_pkg::OP_READ;
          state_nxt = ST_DRAIN_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN_RD: begin
        if (sts.out_space) begin
          cmd.op    = iort_pkg::OP_DELIVER;
          state_nxt = sts.last_del ? ST_IDLE : ST_DRAIN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_more) begin
          cmd.op = iort_pkg::OP_SCAN_STEP;
        end else begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        if (sts.out_space) begin
          cmd.op    = iort_pkg::OP_SCAN_END;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/in_order_receive_tracker.sv
// Top level of the in-order receive tracker: stream ports, controller and datapath.
// Depends on iort_pkg, iort_ctrl and iort_dp.
//
// Takes packet arrivals and request ticks one at a time and hands out packets
// strictly in order of their numbers. Early packets are held in a WINDOW-slot
// store and released as soon as the gap before them closes; old and duplicate
// packets vanish without a result, packets past the window or the transfer come
// back as out-of-window. A tick reports completion once, or lists up to
// nack_limit numbers still missing (an empty request if none); a nack_limit
// of 0 counts as 1 and one above 8 as 8. Timing: an arrival or a tick is
// classified in the cycle after its transfer, where a rejected or old packet
// ends; a held arrival stores its slot as it is classified, then each packet
// delivered takes a slot check, then a handle memory read, up to 64 per
// arrival, and the first check finds nothing when the gap is still open. A
// tick scan visits one number per cycle while no found number waits for
// output space. Output stalls hold up every step that loads the output
// register. The next input is taken once the item in hand has put its last
// result into the output register; that single register holds one waiting
// result, so a short output stall need not hold up the input. No clearing
// pass follows reset: slot valid bits are flip-flops cleared at once.
`default_nettype none

module in_order_receive_tracker #(
  parameter int unsigned WINDOW = iort_pkg::WINDOW_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [iort_pkg::DATA_W-1:0]   in_tdata,  // packet_number, payload_handle
  input  wire logic                          in_tuser,  // req_type
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [iort_pkg::DATA_W-1:0]        out_tdata, // result_number, result_handle
  output logic [iort_pkg::KIND_W-1:0]        out_tuser, // kind
  output logic                               out_tlast,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [iort_pkg::NUM_W-1:0]    cfg_wdata
);

  localparam int unsigned NW  = iort_pkg::NUM_W;
  localparam int unsigned HW  = iort_pkg::HANDLE_W;
  localparam int unsigned PAD = iort_pkg::DATA_W - NW - HW;

  iort_pkg::cmd_t cmd;
  iort_pkg::sts_t sts;
  logic [NW-1:0]  res_number;
  logic [HW-1:0]  res_handle;

  iort_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iort_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_req_type       (in_tuser),
    .in_packet_number  (in_tdata[NW-1:0]),
    .in_payload_handle (in_tdata[NW+HW-1:NW]),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .sts               (sts),
    .out_tready        (out_tready),
    .out_valid         (out_tvalid),
    .out_kind          (out_tuser),
    .out_number        (res_number),
    .out_handle        (res_handle),
    .out_last          (out_tlast)
  );

  assign out_tdata = {{PAD{1'b0}}, res_handle, res_number};

endmodule

`default_nettype wire
